[sv/ecn_marking_packet_queue_top_assert.svh]
// ----------------------------------------------------------------------------
// ECN marking packet queue assertion macros
// Shared property templates for the concurrent checks of the queue.
// ----------------------------------------------------------------------------
`ifndef ECN_MARKING_PACKET_QUEUE_TOP_ASSERT_SVH
`define ECN_MARKING_PACKET_QUEUE_TOP_ASSERT_SVH

// Overlapping implication, checked on every rising clock edge outside reset.
`define ECNQ_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Non-overlapping implication: the consequent is checked in the next cycle.
`define ECNQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/ecnq_pkg.sv]
// ----------------------------------------------------------------------------
// ECN marking packet queue package
// Sizes, status codes, register indexes and shared types of the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecnq_pkg;

   // Queue geometry.
   localparam int QUEUE_DEPTH  = 1024;
   localparam int HANDLE_WIDTH = 32;
   localparam int ADDR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

   // Fixed field widths of the ports.
   localparam int FIELD_W      = 15;
   localparam int LEN_W        = 16;
   localparam int OUT_HANDLE_W = 32;
   localparam int WIRE_W       = 20;
   localparam int STATUS_W     = 3;
   localparam int COUNTER_W    = 32;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 15;

   localparam int ENTRY_W      = 1 + LEN_W + HANDLE_WIDTH;

   // Capacity limits and wire overhead.
   localparam int MIN_CAPACITY   = 4;
   localparam int CAPACITY_RESET = 1024;
   localparam int WIRE_OVERHEAD  = 24;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DEQUEUED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BLOCKED  = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_WATER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_WATER    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKPRESSURE = 2'd3;

   // One stored descriptor.
   typedef struct packed {
      logic                    mark;
      logic [LEN_W-1:0]        length;
      logic [HANDLE_WIDTH-1:0] handle;
   } entry_type;

   // Decision of one transaction, handed from the control to the response stage.
   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic                mark;
      logic                underload;
   } stage_type;

   // Running statistics of the queue.
   typedef struct packed {
      logic [COUNTER_W-1:0] enqueued;
      logic [COUNTER_W-1:0] dequeued;
      logic [COUNTER_W-1:0] dropped;
      logic [CNT_W-1:0]     count;
      logic [CNT_W-1:0]     peak;
   } stats_type;

endpackage

[sv/ecnq_ram.sv]
// ----------------------------------------------------------------------------
// ECN marking packet queue RAM
// Generic simple dual-port memory with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecnq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

[sv/ecnq_ctrl.sv]
// ----------------------------------------------------------------------------
// ECN marking packet queue control
// Decides each transaction, drives the descriptor memory and keeps counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecnq_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           req_operation,
   input  logic [31:0]                    req_packet_handle,
   input  logic [ecnq_pkg::LEN_W-1:0]     req_packet_length,
   input  logic                           req_downstream_overloaded,
   input  logic [ecnq_pkg::FIELD_W-1:0]   capacity_in_use,
   input  logic [ecnq_pkg::FIELD_W-1:0]   mark_level,
   input  logic [ecnq_pkg::FIELD_W-1:0]   low_water_level,
   input  logic                           backpressure_enable,
   output logic                           mem_write_enable,
   output logic [ecnq_pkg::ADDR_W-1:0]    mem_write_address,
   output ecnq_pkg::entry_type            mem_write_entry,
   output logic                           mem_read_enable,
   output logic [ecnq_pkg::ADDR_W-1:0]    mem_read_address,
   output ecnq_pkg::stage_type            stage,
   output ecnq_pkg::stats_type            stats
);

   import ecnq_pkg::*;

   logic [ADDR_W-1:0]    head_ff, head_in;
   logic [ADDR_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     peak_ff, peak_in;
   logic [COUNTER_W-1:0] enq_total_ff, enq_total_in;
   logic [COUNTER_W-1:0] deq_total_ff, deq_total_in;
   logic [COUNTER_W-1:0] drop_total_ff, drop_total_in;
   stage_type            stage_ff, stage_in;

   logic [FIELD_W-1:0]   usable;
   logic                 full;
   logic [CNT_W-1:0]     count_inc;
   logic [CNT_W-1:0]     count_dec;
   logic [ADDR_W-1:0]    head_next;
   logic [ADDR_W-1:0]    tail_next;

   // Capacity is clamped to the range the ring supports.
   always_comb begin
      if (capacity_in_use < FIELD_W'(MIN_CAPACITY)) begin
         usable = FIELD_W'(MIN_CAPACITY);
      end else if (capacity_in_use > FIELD_W'(QUEUE_DEPTH)) begin
         usable = FIELD_W'(QUEUE_DEPTH);
      end else begin
         usable = capacity_in_use;
      end
   end

   assign full      = FIELD_W'(count_ff) >= usable;
   assign count_inc = count_ff + CNT_W'(1);
   assign count_dec = count_ff - CNT_W'(1);
   assign head_next = (head_ff == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + ADDR_W'(1);
   assign tail_next = (tail_ff == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + ADDR_W'(1);

   assign mem_write_address      = tail_ff;
   assign mem_write_entry.handle = HANDLE_WIDTH'(req_packet_handle);
   assign mem_write_entry.length = req_packet_length;
   assign mem_write_entry.mark   = FIELD_W'(count_inc) > mark_level;
   assign mem_read_address       = head_ff;

   always_comb begin
      head_in          = head_ff;
      tail_in          = tail_ff;
      count_in         = count_ff;
      peak_in          = peak_ff;
      enq_total_in     = enq_total_ff;
      deq_total_in     = deq_total_ff;
      drop_total_in    = drop_total_ff;
      stage_in         = '0;
      mem_write_enable = 1'b0;
      mem_read_enable  = 1'b0;
      if (accept) begin
         stage_in.valid = 1'b1;
         if (!req_operation) begin
            if (full) begin
               stage_in.status = ST_DROPPED;
               drop_total_in   = drop_total_ff + COUNTER_W'(1);
            end else begin
               stage_in.status  = ST_ENQUEUED;
               stage_in.mark    = mem_write_entry.mark;
               mem_write_enable = 1'b1;
               tail_in          = tail_next;
               count_in         = count_inc;
               enq_total_in     = enq_total_ff + COUNTER_W'(1);
               if (count_inc > peak_ff) begin
                  peak_in = count_inc;
               end
            end
         end else if (req_downstream_overloaded) begin
            stage_in.status = ST_BLOCKED;
         end else if (count_ff == '0) begin
            stage_in.status = ST_EMPTY;
         end else begin
            // The popped descriptor arrives from memory in the next cycle.
            stage_in.status    = ST_DEQUEUED;
            stage_in.underload = backpressure_enable &&
                                 (FIELD_W'(count_dec) < low_water_level);
            mem_read_enable    = 1'b1;
            head_in            = head_next;
            count_in           = count_dec;
            deq_total_in       = deq_total_ff + COUNTER_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         peak_ff       <= '0;
         enq_total_ff  <= '0;
         deq_total_ff  <= '0;
         drop_total_ff <= '0;
         stage_ff      <= '0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         peak_ff       <= peak_in;
         enq_total_ff  <= enq_total_in;
         deq_total_ff  <= deq_total_in;
         drop_total_ff <= drop_total_in;
         stage_ff      <= stage_in;
      end
   end

   assign stage          = stage_ff;
   assign stats.enqueued = enq_total_ff;
   assign stats.dequeued = deq_total_ff;
   assign stats.dropped  = drop_total_ff;
   assign stats.count    = count_ff;
   assign stats.peak     = peak_ff;

endmodule

[sv/ecnq_rsp.sv]
// ----------------------------------------------------------------------------
// ECN marking packet queue response stage
// Merges the decision with the popped descriptor into the result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecnq_rsp (
   input  logic                              clock,
   input  logic                              reset,
   input  ecnq_pkg::stage_type               stage,
   input  ecnq_pkg::entry_type               read_entry,
   input  ecnq_pkg::stats_type               stats,
   output logic                              rsp_valid,
   output logic [ecnq_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_ecn_marked,
   output logic [ecnq_pkg::OUT_HANDLE_W-1:0] rsp_out_handle,
   output logic [ecnq_pkg::LEN_W-1:0]        rsp_out_length,
   output logic [ecnq_pkg::WIRE_W-1:0]       rsp_wire_bits,
   output logic [ecnq_pkg::FIELD_W-1:0]      rsp_occupancy,
   output logic                              rsp_underload,
   output logic [ecnq_pkg::COUNTER_W-1:0]    rsp_enqueued_total,
   output logic [ecnq_pkg::COUNTER_W-1:0]    rsp_dequeued_total,
   output logic [ecnq_pkg::COUNTER_W-1:0]    rsp_dropped_total,
   output logic [ecnq_pkg::FIELD_W-1:0]      rsp_peak_occupancy
);

   import ecnq_pkg::*;

   localparam int SUM_W = WIRE_W - 3;

   logic                    valid_ff;
   logic [STATUS_W-1:0]     status_ff;
   logic                    mark_ff, mark_in;
   logic [OUT_HANDLE_W-1:0] handle_ff, handle_in;
   logic [LEN_W-1:0]        length_ff, length_in;
   logic [WIRE_W-1:0]       wire_ff, wire_in;
   logic [FIELD_W-1:0]      occ_ff;
   logic                    underload_ff;
   logic [COUNTER_W-1:0]    enq_ff, deq_ff, drop_ff;
   logic [FIELD_W-1:0]      peak_ff;

   logic                    popped;
   logic [SUM_W-1:0]        wire_sum;

   assign popped   = stage.status == ST_DEQUEUED;
   assign wire_sum = SUM_W'(read_entry.length) + SUM_W'(WIRE_OVERHEAD);

   always_comb begin
      mark_in   = stage.mark;
      handle_in = '0;
      length_in = '0;
      wire_in   = '0;
      if (popped) begin
         mark_in   = read_entry.mark;
         handle_in = OUT_HANDLE_W'(read_entry.handle);
         length_in = read_entry.length;
         wire_in   = {wire_sum, 3'b000};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage.valid;
      end
   end

   // The statistics already hold this transaction's effect and nothing later.
   always_ff @(posedge clock) begin
      status_ff    <= stage.status;
      mark_ff      <= mark_in;
      handle_ff    <= handle_in;
      length_ff    <= length_in;
      wire_ff      <= wire_in;
      occ_ff       <= FIELD_W'(stats.count);
      underload_ff <= stage.underload;
      enq_ff       <= stats.enqueued;
      deq_ff       <= stats.dequeued;
      drop_ff      <= stats.dropped;
      peak_ff      <= FIELD_W'(stats.peak);
   end

   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_ecn_marked     = mark_ff;
   assign rsp_out_handle     = handle_ff;
   assign rsp_out_length     = length_ff;
   assign rsp_wire_bits      = wire_ff;
   assign rsp_occupancy      = occ_ff;
   assign rsp_underload      = underload_ff;
   assign rsp_enqueued_total = enq_ff;
   assign rsp_dequeued_total = deq_ff;
   assign rsp_dropped_total  = drop_ff;
   assign rsp_peak_occupancy = peak_ff;

endmodule

[sv/ecn_marking_packet_queue_top.sv]
// ----------------------------------------------------------------------------
// ECN marking packet queue
// Descriptor FIFO with threshold ECN marking, drop on full and statistics.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is offered by raising start with the req_ fields; it is taken
// at a rising edge where start is high and busy is low. req_operation selects
// enqueue (0) or dequeue (1). An enqueue is dropped when the queue holds as
// many descriptors as the clamped capacity, otherwise it is written to the
// descriptor memory and marked when the new occupancy exceeds the high-water
// level. A dequeue is blocked while downstream is overloaded, reports an empty
// queue, or pops the oldest descriptor.
// Every transaction produces one result, shown for exactly one cycle with
// rsp_valid high. The decision passes the stage register of the control,
// then the result registers of the response stage. While busy is low, one
// transaction can be taken every cycle: the decision uses pointers and counters
// held in flip-flops, and the only memory access per transaction is one write
// port slot (enqueue) or one read port slot (dequeue) of the descriptor memory.
// The receiver cannot stall; results are never held back.
// Reset clears pointers, counters and pending results and loads the register
// defaults; busy is high through reset and up to the first edge after it. The
// csr_ port writes a register at a clock edge and must only be used while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecn_marking_packet_queue_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_operation,
   input  logic [31:0]                       req_packet_handle,
   input  logic [ecnq_pkg::LEN_W-1:0]        req_packet_length,
   input  logic                              req_downstream_overloaded,
   input  logic                              csr_write_enable,
   input  logic [ecnq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ecnq_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output logic                              rsp_valid,
   output logic [ecnq_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_ecn_marked,
   output logic [ecnq_pkg::OUT_HANDLE_W-1:0] rsp_out_handle,
   output logic [ecnq_pkg::LEN_W-1:0]        rsp_out_length,
   output logic [ecnq_pkg::WIRE_W-1:0]       rsp_wire_bits,
   output logic [ecnq_pkg::FIELD_W-1:0]      rsp_occupancy,
   output logic                              rsp_underload,
   output logic [ecnq_pkg::COUNTER_W-1:0]    rsp_enqueued_total,
   output logic [ecnq_pkg::COUNTER_W-1:0]    rsp_dequeued_total,
   output logic [ecnq_pkg::COUNTER_W-1:0]    rsp_dropped_total,
   output logic [ecnq_pkg::FIELD_W-1:0]      rsp_peak_occupancy
);

   import ecnq_pkg::*;

   `include "ecn_marking_packet_queue_top_assert.svh"

   // Configuration registers.
   logic [FIELD_W-1:0] capacity_ff, capacity_in;
   logic [FIELD_W-1:0] mark_level_ff, mark_level_in;
   logic [FIELD_W-1:0] low_water_ff, low_water_in;
   logic               backpressure_ff, backpressure_in;

   // busy only covers reset and start-up; afterwards a transaction fits every cycle.
   logic               busy_ff;
   logic               accept;
   logic               pop_taken;

   logic               mem_write_enable;
   logic [ADDR_W-1:0]  mem_write_address;
   entry_type          mem_write_entry;
   logic               mem_read_enable;
   logic [ADDR_W-1:0]  mem_read_address;
   logic [ENTRY_W-1:0] mem_read_data;
   entry_type          read_entry;
   stage_type          stage;
   stats_type          stats;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // A dequeue that finds the queue non-empty and downstream ready.
   assign pop_taken = accept && req_operation && !req_downstream_overloaded &&
                      (stats.count != '0);

   // Register decode. Writing only with no transaction in flight is up to the user.
   always_comb begin
      capacity_in     = capacity_ff;
      mark_level_in   = mark_level_ff;
      low_water_in    = low_water_ff;
      backpressure_in = backpressure_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CAPACITY:     capacity_in     = csr_write_data;
            CSR_HIGH_WATER:   mark_level_in   = csr_write_data;
            CSR_LOW_WATER:    low_water_in    = csr_write_data;
            CSR_BACKPRESSURE: backpressure_in = csr_write_data[0];
            default:          capacity_in     = capacity_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff     <= FIELD_W'(CAPACITY_RESET);
         mark_level_ff   <= '0;
         low_water_ff    <= '0;
         backpressure_ff <= 1'b0;
         busy_ff         <= 1'b1;
      end else begin
         capacity_ff     <= capacity_in;
         mark_level_ff   <= mark_level_in;
         low_water_ff    <= low_water_in;
         backpressure_ff <= backpressure_in;
         busy_ff         <= 1'b0;
      end
   end

   ecnq_ctrl u_ctrl (
      .clock                     (clock),
      .reset                     (reset),
      .accept                    (accept),
      .req_operation             (req_operation),
      .req_packet_handle         (req_packet_handle),
      .req_packet_length         (req_packet_length),
      .req_downstream_overloaded (req_downstream_overloaded),
      .capacity_in_use           (capacity_ff),
      .mark_level                (mark_level_ff),
      .low_water_level           (low_water_ff),
      .backpressure_enable       (backpressure_ff),
      .mem_write_enable          (mem_write_enable),
      .mem_write_address         (mem_write_address),
      .mem_write_entry           (mem_write_entry),
      .mem_read_enable           (mem_read_enable),
      .mem_read_address          (mem_read_address),
      .stage                     (stage),
      .stats                     (stats)
   );

   // Descriptor store. A full ring makes the next enqueue target the slot just
   // read, but the read data is already captured at that edge.
   ecnq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock         (clock),
      .write_enable  (mem_write_enable),
      .write_address (mem_write_address),
      .write_data    (mem_write_entry),
      .read_enable   (mem_read_enable),
      .read_address  (mem_read_address),
      .read_data     (mem_read_data)
   );

   assign read_entry = mem_read_data;

   ecnq_rsp u_rsp (
      .clock              (clock),
      .reset              (reset),
      .stage              (stage),
      .read_entry         (read_entry),
      .stats              (stats),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_ecn_marked     (rsp_ecn_marked),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_out_length     (rsp_out_length),
      .rsp_wire_bits      (rsp_wire_bits),
      .rsp_occupancy      (rsp_occupancy),
      .rsp_underload      (rsp_underload),
      .rsp_enqueued_total (rsp_enqueued_total),
      .rsp_dequeued_total (rsp_dequeued_total),
      .rsp_dropped_total  (rsp_dropped_total),
      .rsp_peak_occupancy (rsp_peak_occupancy)
   );

   // Every accepted transaction yields a result from the result registers.
   `ECNQ_ASSERT_IMPLIES(a_result_follows, clock, reset, accept, ##2 rsp_valid, "result missing")

   // No result appears without a transaction behind it.
   `ECNQ_ASSERT_IMPLIES(a_no_spurious_result, clock, reset, rsp_valid, $past(accept, 2), "spurious")

   // Occupancy never exceeds the ring size.
   `ECNQ_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, stats.count <= CNT_W'(QUEUE_DEPTH), "overflow")

   // A successful pop lowers the occupancy by exactly one.
   `ECNQ_ASSERT_NEXT(a_pop_count, clock, reset, pop_taken, stats.count == $past(stats.count) - 1'b1, "pop")

endmodule

[dv/tb_ecn_marking_packet_queue_top.sv]
// ----------------------------------------------------------------------------
// ECN marking packet queue testbench
// Self-checking test of the descriptor queue: directed corner cases, then
// random enqueue/dequeue traffic under several register settings, each result
// compared field by field against a shadow copy of the queue kept in a class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ecn_marking_packet_queue_top;
   import ecnq_pkg::*;

   // Operation codes of req_operation.
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Cycles without any transaction, result or register write before giving up.
   // The longest sender gap and the path from a request to its result are both
   // far shorter, so this is far above any correct run.
   localparam int STALL_LIMIT = 2000;

   // One result transaction, as seen on the rsp_ ports.
   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic                    ecn_marked;
      logic [OUT_HANDLE_W-1:0] out_handle;
      logic [LEN_W-1:0]        out_length;
      logic [WIRE_W-1:0]       wire_bits;
      logic [FIELD_W-1:0]      occupancy;
      logic                    underload;
      logic [COUNTER_W-1:0]    enqueued_total;
      logic [COUNTER_W-1:0]    dequeued_total;
      logic [COUNTER_W-1:0]    dropped_total;
      logic [FIELD_W-1:0]      peak_occupancy;
   } queue_outcome_type;

   // Shadow of the queue: registers, ring of descriptors, counters, and the
   // outcomes that are still to come out of the block, oldest first.
   class ecn_queue_scoreboard;
      int unsigned       capacity_reg  = CAPACITY_RESET;
      int unsigned       mark_level    = 0;
      int unsigned       low_water     = 0;
      logic              backpressure  = 1'b0;
      entry_type         ring [QUEUE_DEPTH];
      int unsigned       head_idx      = 0;
      int unsigned       tail_idx      = 0;
      int unsigned       fill_level    = 0;
      int unsigned       peak_level    = 0;
      logic [31:0]       enq_count     = '0;
      logic [31:0]       deq_count     = '0;
      logic [31:0]       drop_count    = '0;
      int                mismatches    = 0;
      queue_outcome_type expected_outcomes [$];

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CAPACITY:     capacity_reg = 32'(data);
            CSR_HIGH_WATER:   mark_level   = 32'(data);
            CSR_LOW_WATER:    low_water    = 32'(data);
            CSR_BACKPRESSURE: backpressure = data[0];
            default: ;
         endcase
      endfunction

      // Applies one accepted request to the shadow and queues its outcome.
      function void note_request(logic op, logic [31:0] handle, logic [LEN_W-1:0] length,
                                 logic overloaded);
         queue_outcome_type o;
         entry_type         slot;
         int unsigned       usable;
         o      = '0;
         usable = capacity_reg;
         if (usable < MIN_CAPACITY) usable = MIN_CAPACITY;
         if (usable > QUEUE_DEPTH) usable = QUEUE_DEPTH;
         if (op == OP_ENQUEUE) begin
            // The overload flag has no effect on an enqueue.
            if (fill_level >= usable) begin
               o.status = ST_DROPPED;
               drop_count++;
            end else begin
               fill_level++;
               slot.handle = handle;
               slot.length = length;
               slot.mark   = (fill_level > mark_level);
               ring[tail_idx] = slot;
               tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
               enq_count++;
               if (fill_level > peak_level) peak_level = fill_level;
               o.status     = ST_ENQUEUED;
               o.ecn_marked = slot.mark;
            end
         end else if (overloaded) begin
            o.status = ST_BLOCKED;
         end else if (fill_level == 0) begin
            o.status = ST_EMPTY;
         end else begin
            slot     = ring[head_idx];
            head_idx = (head_idx + 1) % QUEUE_DEPTH;
            fill_level--;
            deq_count++;
            o.status     = ST_DEQUEUED;
            o.ecn_marked = slot.mark;
            o.out_handle = slot.handle;
            o.out_length = slot.length;
            o.wire_bits  = WIRE_W'((int'(slot.length) + WIRE_OVERHEAD) * 8);
            o.underload  = backpressure && (fill_level < low_water);
         end
         o.occupancy      = FIELD_W'(fill_level);
         o.enqueued_total = enq_count;
         o.dequeued_total = deq_count;
         o.dropped_total  = drop_count;
         o.peak_occupancy = FIELD_W'(peak_level);
         expected_outcomes.push_back(o);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h",
                        $realtime, name, want, got);
         end
      endfunction

      function void check_outcome(queue_outcome_type got);
         queue_outcome_type want;
         if (expected_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with no request outstanding, status %0d",
                        $realtime, got.status);
            return;
         end
         want = expected_outcomes.pop_front();
         compare_field("status",         32'(want.status),     32'(got.status));
         compare_field("ecn_marked",     32'(want.ecn_marked), 32'(got.ecn_marked));
         compare_field("out_handle",     want.out_handle,      got.out_handle);
         compare_field("out_length",     32'(want.out_length), 32'(got.out_length));
         compare_field("wire_bits",      32'(want.wire_bits),  32'(got.wire_bits));
         compare_field("occupancy",      32'(want.occupancy),  32'(got.occupancy));
         compare_field("underload",      32'(want.underload),  32'(got.underload));
         compare_field("enqueued_total", want.enqueued_total,  got.enqueued_total);
         compare_field("dequeued_total", want.dequeued_total,  got.dequeued_total);
         compare_field("dropped_total",  want.dropped_total,   got.dropped_total);
         compare_field("peak_occupancy", 32'(want.peak_occupancy),
                       32'(got.peak_occupancy));
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_operation;
   logic [31:0]             req_packet_handle;
   logic [LEN_W-1:0]        req_packet_length;
   logic                    req_downstream_overloaded;
   logic                    csr_write_enable;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_write_data;
   logic                    rsp_valid;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    rsp_ecn_marked;
   logic [OUT_HANDLE_W-1:0] rsp_out_handle;
   logic [LEN_W-1:0]        rsp_out_length;
   logic [WIRE_W-1:0]       rsp_wire_bits;
   logic [FIELD_W-1:0]      rsp_occupancy;
   logic                    rsp_underload;
   logic [COUNTER_W-1:0]    rsp_enqueued_total;
   logic [COUNTER_W-1:0]    rsp_dequeued_total;
   logic [COUNTER_W-1:0]    rsp_dropped_total;
   logic [FIELD_W-1:0]      rsp_peak_occupancy;

   ecn_queue_scoreboard sb = new();
   int gapless_left = 0;
   int stall_cycles = 0;

   ecn_marking_packet_queue_top u_dut (
      .clock                     (clock),
      .reset                     (reset),
      .start                     (start),
      .busy                      (busy),
      .req_operation             (req_operation),
      .req_packet_handle         (req_packet_handle),
      .req_packet_length         (req_packet_length),
      .req_downstream_overloaded (req_downstream_overloaded),
      .csr_write_enable          (csr_write_enable),
      .csr_index                 (csr_index),
      .csr_write_data            (csr_write_data),
      .rsp_valid                 (rsp_valid),
      .rsp_status                (rsp_status),
      .rsp_ecn_marked            (rsp_ecn_marked),
      .rsp_out_handle            (rsp_out_handle),
      .rsp_out_length            (rsp_out_length),
      .rsp_wire_bits             (rsp_wire_bits),
      .rsp_occupancy             (rsp_occupancy),
      .rsp_underload             (rsp_underload),
      .rsp_enqueued_total        (rsp_enqueued_total),
      .rsp_dequeued_total        (rsp_dequeued_total),
      .rsp_dropped_total         (rsp_dropped_total),
      .rsp_peak_occupancy        (rsp_peak_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Monitor. Everything is sampled at the rising edge, where the values seen
   // are those that held during the cycle the edge ends, so the order of the
   // processes within the time step does not matter. A result is checked
   // before the request of the same edge is noted: the result always belongs
   // to an older request, which sits at the front of the queue either way.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1)
            sb.check_outcome({rsp_status, rsp_ecn_marked, rsp_out_handle, rsp_out_length,
                              rsp_wire_bits, rsp_occupancy, rsp_underload,
                              rsp_enqueued_total, rsp_dequeued_total,
                              rsp_dropped_total, rsp_peak_occupancy});
         if (start && busy === 1'b0)
            sb.note_request(req_operation, req_packet_handle, req_packet_length,
                            req_downstream_overloaded);
         if (csr_write_enable)
            sb.set_register(csr_index, csr_write_data);
      end
   end

   // Watchdog: any transaction, result or register write counts as progress.
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1 || csr_write_enable)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d cycles without progress", STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Offers one request and holds it until the block takes it. Afterwards the
   // sender may pause: mostly not at all or for a few cycles, now and then for
   // a long time, and sometimes a run of requests goes out back to back.
   task automatic send_request(input logic op, input logic [31:0] handle,
                               input logic [LEN_W-1:0] length, input logic overloaded);
      int gap;
      int pick;
      start                     <= 1'b1;
      req_operation             <= op;
      req_packet_handle         <= handle;
      req_packet_length         <= length;
      req_downstream_overloaded <= overloaded;
      do @(posedge clock); while (busy !== 1'b0);
      gap = 0;
      if (gapless_left > 0) begin
         gapless_left--;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 3)
            gapless_left = $urandom_range(20, 60);
         else if (pick < 55)
            gap = 0;
         else if (pick < 85)
            gap = $urandom_range(1, 3);
         else if (pick < 97)
            gap = $urandom_range(4, 12);
         else
            gap = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering requests and waits until every outstanding result is back,
   // plus a few cycles so that the pipeline is surely empty.
   task automatic drain_block();
      start <= 1'b0;
      while (sb.expected_outcomes.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // Writes all four registers while the block is idle. The enable is lowered
   // once after the last write so it is never dropped and raised in one step.
   // Only bit 0 of the backpressure register counts; the other bits are noise.
   task automatic configure(input logic [CSR_DATA_W-1:0] cap, input logic [CSR_DATA_W-1:0] high,
                            input logic [CSR_DATA_W-1:0] low, input logic bp);
      drain_block();
      csr_put(CSR_CAPACITY, cap);
      csr_put(CSR_HIGH_WATER, high);
      csr_put(CSR_LOW_WATER, low);
      csr_put(CSR_BACKPRESSURE, (CSR_DATA_W'($urandom) & 15'h7FFE) | CSR_DATA_W'(bp));
      csr_write_enable <= 1'b0;
   endtask

   // One phase of random traffic. enq_pct sets the share of enqueues; a
   // dequeue finds downstream overloaded about one time in seven. Lengths
   // lean toward the extremes now and then.
   task automatic run_phase(input logic [CSR_DATA_W-1:0] cap, input logic [CSR_DATA_W-1:0] high,
                            input logic [CSR_DATA_W-1:0] low, input logic bp,
                            input int count, input int enq_pct);
      logic             op;
      logic [LEN_W-1:0] length;
      int               pick;
      configure(cap, high, low, bp);
      repeat (count) begin
         op   = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
         pick = $urandom_range(0, 9);
         if (pick == 0)
            length = '0;
         else if (pick == 1)
            length = '1;
         else
            length = LEN_W'($urandom);
         send_request(op, $urandom, length, $urandom_range(0, 6) == 0);
      end
   endtask

   initial begin
      reset                     <= 1'b1;
      start                     <= 1'b0;
      req_operation             <= OP_ENQUEUE;
      req_packet_handle         <= '0;
      req_packet_length         <= '0;
      req_downstream_overloaded <= 1'b0;
      csr_write_enable          <= 1'b0;
      csr_index                 <= CSR_CAPACITY;
      csr_write_data            <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: capacity 1024, every packet marked, no underload.
      // An empty queue reports empty, but blocked wins while overloaded.
      send_request(OP_DEQUEUE, $urandom, LEN_W'($urandom), 1'b0);
      send_request(OP_DEQUEUE, $urandom, LEN_W'($urandom), 1'b1);
      // Extremes of handle and length; overload is ignored on an enqueue.
      send_request(OP_ENQUEUE, 32'h0000_0000, 16'h0000, 1'b0);
      send_request(OP_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      send_request(OP_DEQUEUE, $urandom, LEN_W'($urandom), 1'b1);
      send_request(OP_DEQUEUE, $urandom, LEN_W'($urandom), 1'b0);
      send_request(OP_DEQUEUE, $urandom, LEN_W'($urandom), 1'b0);
      send_request(OP_DEQUEUE, $urandom, LEN_W'($urandom), 1'b0);

      // A capacity of zero is raised to the minimum of four. The fifth
      // enqueue is dropped and carries no mark; marks start above two, and
      // draining with backpressure on raises underload below three.
      configure(15'd0, 15'd2, 15'd3, 1'b1);
      send_request(OP_ENQUEUE, 32'hA5A5_A5A5, 16'h0001, 1'b0);
      send_request(OP_ENQUEUE, 32'h5A5A_5A5A, 16'h8000, 1'b0);
      send_request(OP_ENQUEUE, 32'h0123_4567, 16'h7FFF, 1'b0);
      send_request(OP_ENQUEUE, 32'h89AB_CDEF, 16'h00FF, 1'b1);
      send_request(OP_ENQUEUE, 32'hDEAD_BEEF, 16'h1234, 1'b0);
      repeat (4) send_request(OP_DEQUEUE, $urandom, LEN_W'($urandom), 1'b0);

      // A high-water level of 0x4000 never marks. Six entries are left in the
      // queue, then the capacity drops to five (not a power of two) while it is
      // not empty: enqueues drop until the occupancy falls below five.
      configure(15'd8, 15'h4000, 15'd0, 1'b0);
      repeat (6) send_request(OP_ENQUEUE, $urandom, LEN_W'($urandom), 1'b0);
      configure(15'd5, 15'd1, 15'h4000, 1'b1);
      send_request(OP_ENQUEUE, $urandom, LEN_W'($urandom), 1'b0);
      send_request(OP_DEQUEUE, $urandom, LEN_W'($urandom), 1'b0);
      send_request(OP_DEQUEUE, $urandom, LEN_W'($urandom), 1'b0);
      send_request(OP_ENQUEUE, $urandom, LEN_W'($urandom), 1'b0);
      send_request(OP_ENQUEUE, $urandom, LEN_W'($urandom), 1'b0);

      // Random traffic on small capacities, where drops, empty reads, marks
      // and underload all turn up often.
      run_phase(15'd4,  15'd0,    15'd0,    1'b1, 60, 55);
      run_phase(15'd5,  15'd3,    15'd2,    1'b1, 60, 55);
      run_phase(15'd16, 15'd12,   15'd8,    1'b0, 60, 60);
      run_phase(15'd32, 15'h4000, 15'h4000, 1'b1, 60, 50);
      run_phase(15'd0,  15'd2,    15'd4,    1'b1, 60, 50);
      run_phase(15'd64, 15'd20,   15'd10,   1'b1, 50, 65);
      // The largest capacity value is limited to the memory depth. Mostly
      // enqueues fill the whole ring, wrap its pointers and run into drops.
      run_phase(15'h7FFF, 15'd700, 15'd300, 1'b1, 1100, 98);

      drain_block();
      if (sb.mismatches == 0 && sb.expected_outcomes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
